@@ rtl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
`default_nettype none

package skt_pkg;

	localparam int KEY_W    = 32;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;
	localparam int CAP_W    = 5;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	localparam logic REG_ORDER    = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [POS_W-1:0]  position;
	} skt_cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0]    data;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    count;
	} skt_result_t;

	typedef struct packed {
		logic             descending;
		logic [CAP_W-1:0] capacity;
	} skt_cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_PEEK,
		S_REMOVE,
		S_DONE
	} skt_state_t;

endpackage

`default_nettype wire

@@ rtl/skt_regs.sv @@
// APB configuration registers: sort order and capacity.
`default_nettype none

module skt_regs
	import skt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output skt_cfg_t                cfg
);

	logic             descending_q;
	logic [CAP_W-1:0] capacity_q;
	logic             wr_fire;

	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
			capacity_q   <= CAP_RESET;
		end else if (wr_fire) begin
			case (paddr[2])
				REG_ORDER:    descending_q <= pwdata[0];
				REG_CAPACITY: capacity_q   <= pwdata[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ORDER:    prdata = {{(PDATA_W-1){1'b0}}, descending_q};
			REG_CAPACITY: prdata = {{(PDATA_W-CAP_W){1'b0}}, capacity_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.descending = descending_q;
	assign cfg.capacity   = capacity_q;

endmodule

`default_nettype wire

@@ rtl/skt_mem.sv @@
// Key storage: one write port, one read port with registered read data.
`default_nettype none

module skt_mem
	import skt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [KEY_W-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [KEY_W-1:0]         wr_data
);

	logic [KEY_W-1:0] mem_q [DEPTH];
	logic [KEY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/skt_ctrl.sv @@
// Sequencer: runs insert, peek and remove; insert walks the table through one compare unit.
`default_nettype none

module skt_ctrl
	import skt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire skt_cfg_t                 cfg,
	input  wire logic                     cmd_valid,
	output logic                          cmd_stall,
	input  wire skt_cmd_t                 cmd,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output skt_result_t                   result,
	output logic                          rd_en,
	output logic      [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic [KEY_W-1:0]         rd_data,
	output logic                          wr_en,
	output logic      [$clog2(DEPTH)-1:0] wr_addr,
	output logic      [KEY_W-1:0]         wr_data
);

	localparam int AW     = $clog2(DEPTH);
	localparam int CW_MIN = $clog2(DEPTH + 1) + 1;
	localparam int CW     = (CW_MIN > CNT_W) ? CW_MIN : CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	skt_state_t state_q, state_d;

	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       idx_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    carry_q;
	logic                found_q;
	logic [KEY_W-1:0]    res_data_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                result_valid_q;
	skt_result_t         result_q;

	logic                accept;
	logic [CW-1:0]       pos_c;
	logic [CW-1:0]       cap_c;
	logic                full;
	logic                in_range;
	logic                walks;
	logic                take;
	logic                ins_end;
	logic                rem_end;
	logic                out_free;
	logic [STATUS_W-1:0] status_init;
	logic [CW-1:0]       rd_idx;
	logic [CW-1:0]       wr_idx;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign pos_c     = CW'(cmd.position);
	assign cap_c     = CW'(cfg.capacity);
	assign full      = (fill_q >= cap_c) || (fill_q >= DEPTH_C);
	assign in_range  = pos_c < fill_q;
	// shared compare: keep walking while the stored key orders strictly first
	assign walks     = cfg.descending ? (rd_data > key_q) : (rd_data < key_q);
	assign take      = found_q || !walks;
	assign ins_end   = (idx_q == fill_q);
	assign rem_end   = ((idx_q + ONE_C) == fill_q);
	assign out_free  = !result_valid_q || !result_stall;

	always_comb begin
		case (cmd.func)
			FUNC_INSERT: status_init = full ? STAT_FULL : STAT_OK;
			FUNC_PEEK:   status_init = in_range ? STAT_OK : STAT_RANGE;
			FUNC_REMOVE: status_init = in_range ? STAT_OK : STAT_RANGE;
			default:     status_init = STAT_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FUNC_INSERT: state_d = full ? S_DONE : S_INSERT;
						FUNC_PEEK:   state_d = in_range ? S_PEEK : S_DONE;
						FUNC_REMOVE: state_d = in_range ? S_REMOVE : S_DONE;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_INSERT: if (ins_end) state_d = S_DONE;
			S_PEEK:   state_d = S_DONE;
			S_REMOVE: if (rem_end) state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		wr_data = carry_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FUNC_INSERT: begin
							rd_en  = 1'b1;
							rd_idx = '0;
						end
						FUNC_PEEK: begin
							rd_en  = in_range;
							rd_idx = pos_c;
						end
						FUNC_REMOVE: begin
							rd_en  = (pos_c + ONE_C) < fill_q;
							rd_idx = pos_c + ONE_C;
						end
						default: ;
					endcase
				end
			end
			S_INSERT: begin
				// write the carried key, pick up the displaced one
				wr_en = ins_end || take;
				if (!ins_end) begin
					rd_en  = (idx_q + ONE_C) < fill_q;
					rd_idx = idx_q + ONE_C;
				end
			end
			S_REMOVE: begin
				if (!rem_end) begin
					wr_en   = 1'b1;
					wr_data = rd_data;
					rd_en   = (idx_q + TWO_C) < fill_q;
					rd_idx  = idx_q + TWO_C;
				end
			end
			default: ;
		endcase
	end

	assign rd_addr = rd_idx[AW-1:0];
	assign wr_addr = wr_idx[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fill_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INSERT && ins_end)
				fill_q <= fill_q + ONE_C;
			else if (state_q == S_REMOVE && rem_end)
				fill_q <= fill_q - ONE_C;
			if (state_q == S_DONE && out_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q        <= cmd.key;
					carry_q      <= cmd.key;
					found_q      <= 1'b0;
					res_data_q   <= '0;
					res_status_q <= status_init;
					idx_q        <= (cmd.func == FUNC_REMOVE) ? pos_c : '0;
				end
			end
			S_INSERT: begin
				if (!ins_end) begin
					if (take) begin
						carry_q <= rd_data;
						found_q <= 1'b1;
					end
					idx_q <= idx_q + ONE_C;
				end
			end
			S_PEEK: res_data_q <= rd_data;
			S_REMOVE: begin
				if (!rem_end)
					idx_q <= idx_q + ONE_C;
			end
			S_DONE: begin
				if (out_free) begin
					result_q.data   <= res_data_q;
					result_q.status <= res_status_q;
					result_q.count  <= fill_q[CNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill exceeds table depth");

	a_write_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_idx <= fill_q) && (state_q == S_INSERT || state_q == S_REMOVE))
		else $error("table write outside the used range");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_INSERT || state_q == S_REMOVE) |=> fill_q == $past(fill_q))
		else $error("fill changed outside insert or remove");

	a_peek_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PEEK) |-> (idx_q == '0) && (fill_q != '0))
		else $error("peek walk started on an empty table");
`endif

endmodule

`default_nettype wire

@@ rtl/sorted_key_table_top.sv @@
// Sorted key table: insert, peek and remove commands; a rejected command or no-op goes straight to the result.
// Next command is taken the cycle after the result is loaded; no new command is taken while one is in progress.
// Insert walks every stored entry once through the single compare unit and memory port pair.
// Reset clears the sequencer, fill count, output valid and config (ascending, capacity 16).
// Table contents are undefined after reset; only data read from entries below fill is ever used.
`default_nettype none

module sorted_key_table_top
	import skt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire skt_cmd_t           cmd,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output skt_result_t             result
);

	localparam int AW = $clog2(DEPTH);

	skt_cfg_t         cfg;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [KEY_W-1:0] rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;

	skt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	skt_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	skt_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

endmodule

`default_nettype wire
